// File: sv/pnod_pkg.sv
// Package for the piezo note onset detector: field widths, register
// indexes, reset values and the divide-by-three constant.
// Used by the channel interfaces and by the top level.
`timescale 1ns / 1ps
`default_nettype none

package pnod_pkg;

   localparam int NUM_CHANNELS_DEF = 8;

   localparam int SENSOR_W = 3;
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;

   localparam int THR_W    = 16;
   localparam int ATTEN_W  = 25;
   localparam int WINDOW_W = 10;
   localparam int COUNT_W  = 7;
   localparam int MAP_W    = 56;
   localparam int CSR_W    = 56;

   localparam int AMP_W    = 24;
   localparam int PROD_W   = SAMPLE_W + ATTEN_W;
   localparam int AMP_SHIFT = 16;
   localparam int SUM_W    = AMP_W + 2;

   // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT, exact for x below 2^SUM_W
   localparam int DIV3_SHIFT = SUM_W + 1;
   localparam logic [SUM_W-1:0] DIV3_MUL = SUM_W'(((64'd1 << DIV3_SHIFT) + 64'd1) / 3);
   localparam int DIV_PROD_W = 2 * SUM_W;

   localparam logic [AMP_W-1:0]   AMP_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [VEL_W-1:0]   VEL_MAX   = '1;

   typedef enum logic [2:0] {
      CSR_THRESHOLD_ON  = 3'd0,
      CSR_THRESHOLD_OFF = 3'd1,
      CSR_ATTEN_RECIP   = 3'd2,
      CSR_DETECT_WINDOW = 3'd3,
      CSR_PEAK_HOLD     = 3'd4,
      CSR_VELOCITY_MODE = 3'd5,
      CSR_FIXED_VEL     = 3'd6,
      CSR_NOTE_MAP      = 3'd7
   } csr_index_type;

   localparam logic [THR_W-1:0]    THRESHOLD_ON_RST  = 16'd5120;
   localparam logic [THR_W-1:0]    THRESHOLD_OFF_RST = 16'd2560;
   localparam logic [ATTEN_W-1:0]  ATTEN_RECIP_RST   = 25'd16777216;
   localparam logic [WINDOW_W-1:0] DETECT_WINDOW_RST = 10'd100;
   localparam logic [COUNT_W-1:0]  PEAK_HOLD_RST     = 7'd5;
   localparam logic                VELOCITY_MODE_RST = 1'b1;
   localparam logic [VEL_W-1:0]    FIXED_VEL_RST     = 7'd100;
   localparam logic [MAP_W-1:0]    NOTE_MAP_RST      = '0;

endpackage

`default_nettype wire

// File: sv/pnod_if.sv
// Valid/ready channel interfaces of the piezo note onset detector:
// the sample channel and the note message channel.
// Depends on pnod_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pnod_req_if;
   logic                          valid;
   logic                          ready;
   logic [pnod_pkg::SENSOR_W-1:0] sensor;
   logic [pnod_pkg::SAMPLE_W-1:0] sample;
   logic [pnod_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output sensor, output sample, output now_ms, input ready);
   modport sink   (input valid, input sensor, input sample, input now_ms, output ready);
endinterface

interface pnod_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_note_on;
   logic [pnod_pkg::NOTE_W-1:0]   note;
   logic [pnod_pkg::VEL_W-1:0]    velocity;
   logic [pnod_pkg::SENSOR_W-1:0] source_sensor;

   modport source (output valid, output is_note_on, output note, output velocity,
                   output source_sensor, input ready);
   modport sink   (input valid, input is_note_on, input note, input velocity,
                   input source_sensor, output ready);
endinterface

`default_nettype wire

// File: sv/piezo_note_onset_detector.sv
// Piezo note onset detector: a sample word goes in every cycle that req ready
// is high, a note-on or note-off word comes out when a sensor's note state
// changes. Path to the result register: input register, amplitude multiply,
// three-sample sum, divide by three, then the per-sensor note state update,
// which reads and writes that sensor's flip-flops in the same cycle so any
// sensor may follow itself back to back. One word is taken per cycle; req ready
// falls only while the result register is full and not taken and the stages
// behind it are all occupied. Words for sensor indexes at or above
// NUM_CHANNELS are dropped at the input register. Depends on pnod_pkg, pnod_if.
`timescale 1ns / 1ps
`default_nettype none

module piezo_note_onset_detector #(
   parameter int NUM_CHANNELS = pnod_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   pnod_req_if.sink                        req_if,
   pnod_rsp_if.source                      rsp_if,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [pnod_pkg::CSR_W-1:0] csr_wdata
);
   import pnod_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EXT_W = 6;
   localparam int MAP_IDX_W = $clog2(MAP_W);

   // configuration
   logic [THR_W-1:0]    thr_on_ff;
   logic [THR_W-1:0]    thr_off_ff;
   logic [ATTEN_W-1:0]  atten_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [COUNT_W-1:0]  hold_ff;
   logic                vel_mode_ff;
   logic [VEL_W-1:0]    fixed_vel_ff;
   logic [MAP_W-1:0]    note_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_on_ff    <= THRESHOLD_ON_RST;
         thr_off_ff   <= THRESHOLD_OFF_RST;
         atten_ff     <= ATTEN_RECIP_RST;
         window_ff    <= DETECT_WINDOW_RST;
         hold_ff      <= PEAK_HOLD_RST;
         vel_mode_ff  <= VELOCITY_MODE_RST;
         fixed_vel_ff <= FIXED_VEL_RST;
         note_map_ff  <= NOTE_MAP_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD_ON:  thr_on_ff    <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_OFF: thr_off_ff   <= csr_wdata[THR_W-1:0];
            CSR_ATTEN_RECIP:   atten_ff     <= csr_wdata[ATTEN_W-1:0];
            CSR_DETECT_WINDOW: window_ff    <= csr_wdata[WINDOW_W-1:0];
            CSR_PEAK_HOLD:     hold_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_VELOCITY_MODE: vel_mode_ff  <= csr_wdata[0];
            CSR_FIXED_VEL:     fixed_vel_ff <= csr_wdata[VEL_W-1:0];
            CSR_NOTE_MAP:      note_map_ff  <= csr_wdata[MAP_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline registers
   logic                in_vld_ff;
   logic [SENSOR_W-1:0] in_sensor_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic [TIME_W-1:0]   in_now_ff;

   logic                amp_vld_ff;
   logic [SENSOR_W-1:0] amp_sensor_ff;
   logic [TIME_W-1:0]   amp_now_ff;
   logic [AMP_W-1:0]    amp_ff;

   logic                sum_vld_ff;
   logic [SENSOR_W-1:0] sum_sensor_ff;
   logic [TIME_W-1:0]   sum_now_ff;
   logic [SUM_W-1:0]    sum_ff;

   logic                avg_vld_ff;
   logic [SENSOR_W-1:0] avg_sensor_ff;
   logic [TIME_W-1:0]   avg_now_ff;
   logic [AMP_W-1:0]    avg_ff;

   logic                rsp_vld_ff;
   logic                rsp_on_ff;
   logic [NOTE_W-1:0]   rsp_note_ff;
   logic [VEL_W-1:0]    rsp_vel_ff;
   logic [SENSOR_W-1:0] rsp_sensor_ff;

   // a stage loads when it is empty or its word moves on
   logic ld_out, ld_avg, ld_sum, ld_amp, ld_in;
   assign ld_out = !rsp_vld_ff || rsp_if.ready;
   assign ld_avg = !avg_vld_ff || ld_out;
   assign ld_sum = !sum_vld_ff || ld_avg;
   assign ld_amp = !amp_vld_ff || ld_sum;
   assign ld_in  = !in_vld_ff || ld_amp;
   assign req_if.ready = ld_in;

   logic sensor_ok;
   assign sensor_ok = 32'(req_if.sensor) < NUM_CHANNELS;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (ld_in) begin
         in_vld_ff <= req_if.valid && sensor_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_in) begin
         in_sensor_ff <= req_if.sensor;
         in_sample_ff <= req_if.sample;
         in_now_ff    <= req_if.now_ms;
      end
   end

   // amplitude = sample * atten_recip >> 16, saturated to 24 bits
   logic [PROD_W-1:0] amp_prod;
   logic [AMP_W-1:0]  amp_in;
   assign amp_prod = PROD_W'(in_sample_ff) * PROD_W'(atten_ff);
   assign amp_in   = amp_prod[PROD_W-1] ? AMP_MAX : amp_prod[AMP_SHIFT +: AMP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_vld_ff <= 1'b0;
      end else if (ld_amp) begin
         amp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_amp) begin
         amp_sensor_ff <= in_sensor_ff;
         amp_now_ff    <= in_now_ff;
         amp_ff        <= amp_in;
      end
   end

   // amplitude history, updated in order as each word leaves this stage
   logic [AMP_W-1:0] prev1_ff [NUM_CHANNELS];
   logic [AMP_W-1:0] prev2_ff [NUM_CHANNELS];
   logic [EXT_W-1:0] amp_sensor_ext;
   logic [IDX_W-1:0] amp_idx;
   logic [SUM_W-1:0] sum_in;
   assign amp_sensor_ext = EXT_W'(amp_sensor_ff);
   assign amp_idx = amp_sensor_ext[IDX_W-1:0];
   assign sum_in  = SUM_W'(amp_ff) + SUM_W'(prev1_ff[amp_idx]) + SUM_W'(prev2_ff[amp_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            prev1_ff[i] <= '0;
            prev2_ff[i] <= '0;
         end
      end else if (amp_vld_ff && ld_sum) begin
         prev1_ff[amp_idx] <= amp_ff;
         prev2_ff[amp_idx] <= prev1_ff[amp_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else if (ld_sum) begin
         sum_vld_ff <= amp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_sum) begin
         sum_sensor_ff <= amp_sensor_ff;
         sum_now_ff    <= amp_now_ff;
         sum_ff        <= sum_in;
      end
   end

   // divide by three through the reciprocal
   logic [DIV_PROD_W-1:0] div_prod;
   logic [AMP_W-1:0]      avg_in;
   assign div_prod = DIV_PROD_W'(sum_ff) * DIV_PROD_W'(DIV3_MUL);
   assign avg_in   = div_prod[DIV3_SHIFT +: AMP_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff <= 1'b0;
      end else if (ld_avg) begin
         avg_vld_ff <= sum_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_avg) begin
         avg_sensor_ff <= sum_sensor_ff;
         avg_now_ff    <= sum_now_ff;
         avg_ff        <= avg_in;
      end
   end

   // per-sensor note state
   logic                active_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]   last_ff   [NUM_CHANNELS];
   logic [AMP_W-1:0]    peak_ff   [NUM_CHANNELS];
   logic [COUNT_W-1:0]  fall_ff   [NUM_CHANNELS];
   logic                sent_ff   [NUM_CHANNELS];

   logic [EXT_W-1:0] avg_sensor_ext;
   logic [IDX_W-1:0] avg_idx;
   assign avg_sensor_ext = EXT_W'(avg_sensor_ff);
   assign avg_idx = avg_sensor_ext[IDX_W-1:0];

   logic [MAP_IDX_W-1:0] note_base;
   assign note_base = MAP_IDX_W'(NOTE_W * int'(avg_sensor_ff));

   logic                cur_active, cur_sent;
   logic [TIME_W-1:0]   cur_last, dt;
   logic [AMP_W-1:0]    cur_peak;
   logic [COUNT_W-1:0]  cur_fall;
   logic                above_on, below_off, in_window, timed_out;
   logic                active_in, sent_in;
   logic [TIME_W-1:0]   last_in;
   logic [AMP_W-1:0]    peak_in;
   logic [COUNT_W-1:0]  fall_in;
   logic                emit, emit_on;
   logic [VEL_W-1:0]    emit_vel;

   assign cur_active = active_ff[avg_idx];
   assign cur_sent   = sent_ff[avg_idx];
   assign cur_last   = last_ff[avg_idx];
   assign cur_peak   = peak_ff[avg_idx];
   assign cur_fall   = fall_ff[avg_idx];
   assign dt         = avg_now_ff - cur_last;
   assign above_on   = avg_ff > AMP_W'(thr_on_ff);
   assign below_off  = avg_ff < AMP_W'(thr_off_ff);
   assign in_window  = dt <= TIME_W'(window_ff);
   assign timed_out  = dt >= TIME_W'(window_ff);

   always_comb begin
      active_in = cur_active;
      sent_in   = cur_sent;
      last_in   = cur_last;
      peak_in   = cur_peak;
      fall_in   = cur_fall;
      emit      = 1'b0;
      emit_on   = 1'b0;
      emit_vel  = '0;
      if (vel_mode_ff) begin
         if (!cur_active && above_on) begin
            active_in = 1'b1;
            last_in   = avg_now_ff;
            peak_in   = avg_ff;
            sent_in   = 1'b0;
            fall_in   = '0;
         end else if (cur_active && above_on && in_window) begin
            if (cur_peak < avg_ff) begin
               peak_in = avg_ff;
            end else if (cur_fall != COUNT_MAX) begin
               fall_in = cur_fall + 1'b1;
            end
            last_in = avg_now_ff;
            if (fall_in >= hold_ff && !cur_sent) begin
               emit     = 1'b1;
               emit_on  = 1'b1;
               // integer part of the peak, saturated
               emit_vel = (|peak_in[AMP_W-1:8+VEL_W]) ? VEL_MAX : peak_in[8 +: VEL_W];
               sent_in  = 1'b1;
            end
         end else if (cur_active && (below_off || timed_out)) begin
            active_in = 1'b0;
            peak_in   = '0;
            emit      = 1'b1;
         end
      end else begin
         if (!cur_active && above_on) begin
            active_in = 1'b1;
            last_in   = avg_now_ff;
            emit      = 1'b1;
            emit_on   = 1'b1;
            emit_vel  = fixed_vel_ff;
         end else if (cur_active && below_off) begin
            active_in = 1'b0;
            emit      = 1'b1;
         end else if (cur_active && above_on && timed_out) begin
            // retrigger
            last_in  = avg_now_ff;
            emit     = 1'b1;
            emit_on  = 1'b1;
            emit_vel = fixed_vel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            last_ff[i]   <= '0;
            peak_ff[i]   <= '0;
            fall_ff[i]   <= '0;
            sent_ff[i]   <= 1'b0;
         end
      end else if (avg_vld_ff && ld_out) begin
         active_ff[avg_idx] <= active_in;
         last_ff[avg_idx]   <= last_in;
         peak_ff[avg_idx]   <= peak_in;
         fall_ff[avg_idx]   <= fall_in;
         sent_ff[avg_idx]   <= sent_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ld_out) begin
         rsp_vld_ff <= avg_vld_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_out) begin
         rsp_on_ff     <= emit_on;
         rsp_note_ff   <= note_map_ff[note_base +: NOTE_W];
         rsp_vel_ff    <= emit_vel;
         rsp_sensor_ff <= avg_sensor_ff;
      end
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.is_note_on    = rsp_on_ff;
   assign rsp_if.note          = rsp_note_ff;
   assign rsp_if.velocity      = rsp_vel_ff;
   assign rsp_if.source_sensor = rsp_sensor_ff;

   // input stalls only behind a full, untaken result register
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_vld_ff && !rsp_if.ready))
      else $error("input stalled without a blocked result word");

   // unknown sensors never enter the pipeline
   a_sensor_range: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |-> (32'(in_sensor_ff) < NUM_CHANNELS))
      else $error("out-of-range sensor in the pipeline");

   // note-off words carry zero velocity
   a_off_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_on_ff) |-> (rsp_vel_ff == '0))
      else $error("note-off with nonzero velocity");

endmodule

`default_nettype wire

// File: tb/piezo_note_onset_detector_checker.sv
// Scoreboard for the piezo note onset detector: snoops the sample, note and
// register ports, keeps its own per-sensor note tracking and checks every note word.
// Depends on pnod_pkg and the channel interfaces in pnod_if.
`timescale 1ns / 1ps
`default_nettype none

module piezo_note_onset_detector_checker #(
   parameter int NUM_CHANNELS = pnod_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   pnod_req_if                             req_if,
   pnod_rsp_if                             rsp_if,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [pnod_pkg::CSR_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              notes_pending
);
   import pnod_pkg::*;

   typedef struct packed {
      logic                is_note_on;
      logic [NOTE_W-1:0]   note;
      logic [VEL_W-1:0]    velocity;
      logic [SENSOR_W-1:0] source_sensor;
   } note_word_type;

   note_word_type notes_due[$];
   note_word_type oldest;

   // register shadow
   logic [THR_W-1:0]    on_level;
   logic [THR_W-1:0]    off_level;
   logic [ATTEN_W-1:0]  recip;
   logic [WINDOW_W-1:0] window_ms;
   logic [COUNT_W-1:0]  hold_need;
   logic                peak_mode;
   logic [VEL_W-1:0]    test_vel;
   logic [MAP_W-1:0]    note_map_q;

   // per-sensor note tracking
   logic                sounding [NUM_CHANNELS];
   logic [TIME_W-1:0]   last_hit [NUM_CHANNELS];
   logic [AMP_W-1:0]    peak     [NUM_CHANNELS];
   logic [COUNT_W-1:0]  falls    [NUM_CHANNELS];
   logic                sent     [NUM_CHANNELS];
   logic [AMP_W-1:0]    amp_d1   [NUM_CHANNELS];
   logic [AMP_W-1:0]    amp_d2   [NUM_CHANNELS];

   task automatic queue_word(input logic note_on, input int s, input logic [VEL_W-1:0] vel);
      note_word_type w;
      w.is_note_on = note_on;
      w.note = note_map_q[NOTE_W*s +: NOTE_W];
      w.velocity = vel;
      w.source_sensor = SENSOR_W'(s);
      notes_due.push_back(w);
   endtask

   task automatic follow_sample(input int s, input logic [SAMPLE_W-1:0] sample,
                                input logic [TIME_W-1:0] now);
      logic [PROD_W-1:0] prod;
      logic [AMP_W-1:0]  amp;
      logic [AMP_W-1:0]  avg;
      logic [SUM_W-1:0]  sum;
      logic [TIME_W-1:0] dt;
      logic [15:0]       whole;
      logic              above;
      logic              below;
      if (s >= NUM_CHANNELS) return;
      prod = (PROD_W'(sample) * PROD_W'(recip)) >> AMP_SHIFT;
      amp = (prod > PROD_W'(AMP_MAX)) ? AMP_MAX : prod[AMP_W-1:0];
      sum = SUM_W'(amp) + SUM_W'(amp_d1[s]) + SUM_W'(amp_d2[s]);
      avg = AMP_W'(sum / SUM_W'(3));
      dt = now - last_hit[s];
      above = avg > AMP_W'(on_level);
      below = avg < AMP_W'(off_level);
      if (peak_mode) begin
         if (!sounding[s] && above) begin
            sounding[s] = 1'b1;
            last_hit[s] = now;
            peak[s] = avg;
            sent[s] = 1'b0;
            falls[s] = '0;
         end else if (sounding[s] && above && dt <= TIME_W'(window_ms)) begin
            if (peak[s] < avg) begin
               peak[s] = avg;
            end else if (falls[s] != COUNT_MAX) begin
               falls[s] = falls[s] + 1'b1;
            end
            last_hit[s] = now;
            if (falls[s] >= hold_need && !sent[s]) begin
               whole = peak[s][AMP_W-1:8];
               queue_word(1'b1, s, (whole > 16'(VEL_MAX)) ? VEL_MAX : whole[VEL_W-1:0]);
               sent[s] = 1'b1;
            end
         end else if (sounding[s] && (below || dt >= TIME_W'(window_ms))) begin
            // release also covers a note whose note-on never went out
            sounding[s] = 1'b0;
            peak[s] = '0;
            queue_word(1'b0, s, '0);
         end
      end else begin
         // fixed mode leaves peak, fall count and sent flag alone
         if (!sounding[s] && above) begin
            sounding[s] = 1'b1;
            last_hit[s] = now;
            queue_word(1'b1, s, test_vel);
         end else if (sounding[s] && below) begin
            sounding[s] = 1'b0;
            queue_word(1'b0, s, '0);
         end else if (sounding[s] && above && dt >= TIME_W'(window_ms)) begin
            last_hit[s] = now;
            queue_word(1'b1, s, test_vel);
         end
      end
      amp_d2[s] = amp_d1[s];
      amp_d1[s] = amp;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         on_level = THRESHOLD_ON_RST;
         off_level = THRESHOLD_OFF_RST;
         recip = ATTEN_RECIP_RST;
         window_ms = DETECT_WINDOW_RST;
         hold_need = PEAK_HOLD_RST;
         peak_mode = VELOCITY_MODE_RST;
         test_vel = FIXED_VEL_RST;
         note_map_q = NOTE_MAP_RST;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            sounding[i] = 1'b0;
            last_hit[i] = '0;
            peak[i] = '0;
            falls[i] = '0;
            sent[i] = 1'b0;
            amp_d1[i] = '0;
            amp_d2[i] = '0;
         end
         notes_due.delete();
         fail_count = 0;
         notes_pending <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (notes_due.size() == 0) begin
               $error("note word with nothing expected: on %0b note %0d vel %0d sensor %0d",
                      rsp_if.is_note_on, rsp_if.note, rsp_if.velocity, rsp_if.source_sensor);
               fail_count++;
            end else begin
               oldest = notes_due.pop_front();
               check_field("is_note_on", 32'(oldest.is_note_on), 32'(rsp_if.is_note_on));
               check_field("note", 32'(oldest.note), 32'(rsp_if.note));
               check_field("velocity", 32'(oldest.velocity), 32'(rsp_if.velocity));
               check_field("source_sensor", 32'(oldest.source_sensor),
                           32'(rsp_if.source_sensor));
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD_ON:  on_level = csr_wdata[THR_W-1:0];
               CSR_THRESHOLD_OFF: off_level = csr_wdata[THR_W-1:0];
               CSR_ATTEN_RECIP:   recip = csr_wdata[ATTEN_W-1:0];
               CSR_DETECT_WINDOW: window_ms = csr_wdata[WINDOW_W-1:0];
               CSR_PEAK_HOLD:     hold_need = csr_wdata[COUNT_W-1:0];
               CSR_VELOCITY_MODE: peak_mode = csr_wdata[0];
               CSR_FIXED_VEL:     test_vel = csr_wdata[VEL_W-1:0];
               CSR_NOTE_MAP:      note_map_q = csr_wdata[MAP_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            follow_sample(int'(req_if.sensor), req_if.sample, req_if.now_ms);
         end
         notes_pending <= notes_due.size();
      end
   end

endmodule

`default_nettype wire

// File: tb/piezo_note_onset_detector_test.sv
// Top of the piezo note onset detector testbench: clock, reset, register writes,
// sample stimulus shaped as drum strikes, note port stalls and the verdict.
// Depends on pnod_pkg, pnod_if, the detector and its scoreboard module.
`timescale 1ns / 1ps
`default_nettype none

module piezo_note_onset_detector_test;
   import pnod_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int SENSORS = NUM_CHANNELS_DEF;

   typedef enum logic [1:0] {ENV_QUIET, ENV_RISE, ENV_HOLD} envelope_stage_type;

   typedef struct {
      int unsigned      on_level;
      int unsigned      off_level;
      int unsigned      recip;
      int unsigned      window_ms;
      int unsigned      hold_need;
      int unsigned      peak_mode;
      int unsigned      test_vel;
      logic [MAP_W-1:0] map;
      int               items;
   } setting_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [2:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               fail_count;
   int               notes_pending;

   pnod_req_if req_bus();
   pnod_rsp_if rsp_bus();

   piezo_note_onset_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   piezo_note_onset_detector_checker note_watch (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_bus),
      .rsp_if        (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .notes_pending (notes_pending)
   );

   always #2 clock = ~clock;

   // settings as written, used only to shape the strikes
   int unsigned on_level = THRESHOLD_ON_RST;
   int unsigned off_level = THRESHOLD_OFF_RST;
   int unsigned recip = ATTEN_RECIP_RST;
   int unsigned window_ms = DETECT_WINDOW_RST;

   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned tick = 0;
   int unsigned stall_left = 0;

   envelope_stage_type stage  [SENSORS];
   longint             level  [SENSORS];
   longint             target [SENSORS];
   int                 left   [SENSORS];
   logic [TIME_W-1:0]  stamp  [SENSORS];

   function automatic logic [SAMPLE_W-1:0] amp_to_sample(input longint amp);
      longint raw;
      if (recip == 0) return SAMPLE_W'($urandom());
      raw = (amp <<< AMP_SHIFT) / longint'(recip);
      if (raw > 65535) raw = 65535;
      if (raw < 0) raw = 0;
      return SAMPLE_W'(raw);
   endfunction

   task automatic send_sample(input logic [SENSOR_W-1:0] sensor,
                              input logic [SAMPLE_W-1:0] sample,
                              input logic [TIME_W-1:0] now);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_bus.valid = 1'b1;
      req_bus.sensor = sensor;
      req_bus.sample = sample;
      req_bus.now_ms = now;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait out every expected note word, then the words that make no note
   task automatic drain();
      req_bus.valid = 1'b0;
      while (notes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // note port stalls: free running, random, then long on/off stretches
   always @(negedge clock) begin
      case ((tick >> 9) % 3)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left == 0) begin
               rsp_bus.ready <= ~rsp_bus.ready;
               stall_left = $urandom_range(1, 30);
            end else begin
               stall_left--;
            end
         end
      endcase
      tick++;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      setting_type         plan [8];
      int                  s;
      int                  r;
      bit                  steady;
      longint              level_min;
      logic [TIME_W-1:0]   dt;
      logic [SAMPLE_W-1:0] smp;

      req_bus.valid = 1'b0;
      req_bus.sensor = '0;
      req_bus.sample = '0;
      req_bus.now_ms = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      plan[0] = '{12800, 6400, 65536, 50, 3, 1, 0, MAP_W'({$urandom(), $urandom()}), 200};
      // zero thresholds, a small attenuation reciprocal, zero window and zero hold count
      plan[1] = '{0, 0, 16777, 0, 0, 1, 127, '1, 150};
      // longest hold, a window of 1000, on and off at the same level
      plan[2] = '{51200, 51200, 16777216, 1000, 127, 1, 100,
                  MAP_W'({$urandom(), $urandom()}), 400};
      plan[3] = '{3000, 1500, 1 << 20, 20, 5, 0, 0, MAP_W'({$urandom(), $urandom()}), 200};
      // amplitude saturates here
      plan[4] = '{65535, 40000, 33554431, 200, 1, 1, 127,
                  MAP_W'({$urandom(), $urandom()}), 150};
      plan[5] = '{1000, 60000, 16777217, 1023, 50, 0, 127,
                  MAP_W'({$urandom(), $urandom()}), 150};
      for (int p = 6; p < 8; p++) begin
         plan[p] = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 33554431), $urandom_range(0, 1023),
                     $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 127),
                     MAP_W'({$urandom(), $urandom()}), 175};
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full-scale strike on sensor 0: peak velocity saturates, then a timeout release
      send_sample(3'd0, 16'd0, 32'd0);
      send_sample(3'd0, 16'hFFFF, 32'd10);
      send_sample(3'd0, 16'hFFFF, 32'd20);
      send_sample(3'd0, 16'hFFFF, 32'd30);
      for (int k = 0; k < 5; k++) send_sample(3'd0, 16'hFFFF, 32'd40 + 32'(10 * k));
      send_sample(3'd0, 16'd0, 32'd300);
      // average sitting exactly on each threshold, released before any note-on
      send_sample(3'd1, 16'd20, 32'd0);
      send_sample(3'd1, 16'd20, 32'd1);
      send_sample(3'd1, 16'd20, 32'd2);
      send_sample(3'd1, 16'd21, 32'd3);
      send_sample(3'd1, 16'd10, 32'd4);
      send_sample(3'd1, 16'd10, 32'd5);
      send_sample(3'd1, 16'd10, 32'd6);
      send_sample(3'd1, 16'd9, 32'd7);
      // timestamps across the 2^32 wrap, gap equal to the window, then one past it
      send_sample(3'd7, 16'hFFFF, 32'hFFFF_FFF0);
      send_sample(3'd7, 16'hFFFF, 32'h0000_0005);
      send_sample(3'd7, 16'd0, 32'h0000_0069);
      send_sample(3'd7, 16'd0, 32'h0000_00CE);
      drain();

      for (int i = 0; i < SENSORS; i++) begin
         stage[i] = ENV_QUIET;
         level[i] = 0;
         target[i] = 0;
         left[i] = 0;
         stamp[i] = 32'd0 - 32'($urandom_range(0, 20000));
      end

      for (int p = 0; p < 8; p++) begin
         on_level = plan[p].on_level;
         off_level = plan[p].off_level;
         recip = plan[p].recip;
         window_ms = plan[p].window_ms;
         write_reg(CSR_THRESHOLD_ON, CSR_W'(plan[p].on_level));
         write_reg(CSR_THRESHOLD_OFF, CSR_W'(plan[p].off_level));
         write_reg(CSR_ATTEN_RECIP, CSR_W'(plan[p].recip));
         write_reg(CSR_DETECT_WINDOW, CSR_W'(plan[p].window_ms));
         write_reg(CSR_PEAK_HOLD, CSR_W'(plan[p].hold_need));
         write_reg(CSR_VELOCITY_MODE, CSR_W'(plan[p].peak_mode));
         write_reg(CSR_FIXED_VEL, CSR_W'(plan[p].test_vel));
         write_reg(CSR_NOTE_MAP, CSR_W'(plan[p].map));
         level_min = longint'(on_level) + longint'(on_level / 8) + 300;

         for (int n = 0; n < plan[p].items; n++) begin
            // one sensor gets most of the words so long strikes can play out
            s = ($urandom_range(0, 4) < 3) ? p : $urandom_range(0, SENSORS - 1);
            steady = (stage[s] == ENV_HOLD) && (left[s] > 12);
            case (stage[s])
               ENV_QUIET: begin
                  level[s] = longint'($urandom_range(0, off_level));
                  if ($urandom_range(0, 2) == 0) begin
                     stage[s] = ENV_RISE;
                     left[s] = $urandom_range(1, 3);
                     target[s] = longint'(on_level) + 1 +
                                 longint'($urandom_range(0, on_level * 3 + 40000));
                  end
               end
               ENV_RISE: begin
                  level[s] = level[s] + (target[s] - level[s]) / left[s];
                  left[s]--;
                  if (left[s] == 0) begin
                     stage[s] = ENV_HOLD;
                     left[s] = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 150) :
                                                              $urandom_range(1, 12);
                  end
               end
               default: begin
                  // slow decay with the odd bump, kept above the on level
                  if ($urandom_range(0, 7) == 0) begin
                     level[s] = level[s] + level[s] / 16;
                  end else begin
                     level[s] = level[s] - level[s] * longint'($urandom_range(0, 2)) / 128;
                  end
                  if (level[s] < level_min) level[s] = level_min;
                  left[s]--;
                  if (left[s] == 0) stage[s] = ENV_QUIET;
               end
            endcase

            r = $urandom_range(0, 99);
            if (steady || r < 78) begin
               dt = $urandom_range(0, window_ms / 2);
            end else if (r < 86) begin
               dt = window_ms;
            end else if (r < 92) begin
               dt = window_ms + 1;
            end else begin
               dt = $urandom();
            end
            stamp[s] = stamp[s] + dt;

            if (!steady && $urandom_range(0, 9) == 0) begin
               smp = SAMPLE_W'($urandom());
               stamp[s] = $urandom();
            end else begin
               smp = amp_to_sample(level[s]);
            end
            send_sample(SENSOR_W'(s), smp, stamp[s]);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
